/* src/nfha_pkg.sv */
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared types and codes for the next-fit heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [2:0] ST_NO_SPACE  = 3'd2;
   localparam logic [2:0] ST_DOUBLE    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   localparam logic [1:0] HDR_NONE = 2'd0;
   localparam logic [1:0] HDR_ADD  = 2'd1;
   localparam logic [1:0] HDR_SUB  = 2'd2;

   typedef struct packed {
      logic        op;
      logic [15:0] req_size;
      logic [15:0] req_address;
   } req_type;

   typedef struct packed {
      logic [15:0] grant_address;
      logic [2:0]  status;
      logic [15:0] free_bytes;
   } rsp_type;

   typedef struct packed {
      logic       sub_b;
      logic [1:0] hdr;
   } alu_ctrl_type;

endpackage

/* src/next_fit_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// next_fit_heap_allocator_unit
// Next-fit allocator over one heap region with a ring of sections held in
// RAM; frees coalesce with free neighbors.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_data (op, req_size, req_address)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_data (grant_address, status, free_bytes)
//
//  Allocate: visits sections one by one from the root, up to the live
//  sections, then takes a section whole or splits it, or reports a full
//  table when a split is needed; a zero-size allocate answers the cycle
//  after its transfer.
//  Free: scans the sections for the address, checks it, then checks each
//  neighbor and merges it when free; one shared adder and one RAM read
//  port serialize these steps. After reset, S_INIT writes the first section.
//  A new transfer is taken only when the result slot is empty or draining.
// ----------------------------------------------------------------------------
module next_fit_heap_allocator_unit #(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_SECTIONS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nfha_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nfha_pkg::rsp_type rsp_data
);
   import nfha_pkg::*;

   localparam int SW = (($clog2(HEAP_BYTES) + 1) > 17) ? ($clog2(HEAP_BYTES) + 1) : 17;
   localparam int IW = $clog2(MAX_SECTIONS);
   localparam int CW = $clog2(MAX_SECTIONS + 1);
   localparam int RW = SW + 2;
   localparam logic [SW-1:0] HEAP_INIT = SW'(HEAP_BYTES - HEADER_BYTES);

   localparam logic [4:0] S_INIT    = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_A_SRCH  = 5'd2;
   localparam logic [4:0] S_A_FIT   = 5'd3;
   localparam logic [4:0] S_A_WHOLE = 5'd4;
   localparam logic [4:0] S_A_SPL1  = 5'd5;
   localparam logic [4:0] S_A_SPL2  = 5'd6;
   localparam logic [4:0] S_A_GRANT = 5'd7;
   localparam logic [4:0] S_F_SCAN  = 5'd8;
   localparam logic [4:0] S_F_CHK   = 5'd9;
   localparam logic [4:0] S_M_RC    = 5'd10;
   localparam logic [4:0] S_M_LC    = 5'd11;
   localparam logic [4:0] S_M_LO    = 5'd12;
   localparam logic [4:0] S_M_CMP   = 5'd13;
   localparam logic [4:0] S_M_MRG   = 5'd14;
   localparam logic [4:0] S_M_FH    = 5'd15;
   localparam logic [4:0] S_RT_LD   = 5'd16;
   localparam logic [4:0] S_RT_LNK  = 5'd17;

   logic [4:0]    state_ff, state_in;
   logic [IW-1:0] root_ff, root_in;
   logic [CW-1:0] used_ff, used_in;
   logic [SW-1:0] free_ff, free_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic          phase_ff, phase_in;
   logic [15:0]   req_size_ff, req_size_in;
   logic [15:0]   req_addr_ff, req_addr_in;
   logic [SW-1:0] c_st_ff, c_st_in;
   logic [SW-1:0] c_sz_ff, c_sz_in;
   logic          c_tk_ff, c_tk_in;
   logic [IW-1:0] c_nx_ff, c_nx_in;
   logic [IW-1:0] o_idx_ff, o_idx_in;
   logic [SW-1:0] o_st_ff, o_st_in;
   logic [SW-1:0] o_sz_ff, o_sz_in;
   logic          o_tk_ff, o_tk_in;
   logic [IW-1:0] o_nx_ff, o_nx_in;
   logic [SW-1:0] tmp_ff, tmp_in;
   logic [IW-1:0] l_idx_ff, l_idx_in;
   logic [SW-1:0] l_sz_ff, l_sz_in;
   logic [IW-1:0] r_idx_ff, r_idx_in;
   logic [SW-1:0] r_sz_ff, r_sz_in;
   logic [IW-1:0] r_nx_ff, r_nx_in;
   logic [IW-1:0] lst_nx_ff, lst_nx_in;
   logic [IW-1:0] lst_pv_ff, lst_pv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [IW-1:0] rd_addr;
   logic [SW-1:0] rd_st, rd_sz;
   logic          rd_tk;
   logic [IW-1:0] rd_nx, rd_pv;

   logic          we_st, we_sz, we_tk, we_nx, we_pv;
   logic [IW-1:0] wa_st, wa_sz, wa_tk, wa_nx, wa_pv;
   logic [SW-1:0] wd_st, wd_sz;
   logic          wd_tk;
   logic [IW-1:0] wd_nx, wd_pv;

   alu_ctrl_type  alu_ctrl;
   logic [SW-1:0] alu_a, alu_b;
   logic [RW-1:0] alu_res;
   logic          alu_zero, alu_neg;

   logic [SW-1:0] req_ext, addr_ext;
   logic [CW-1:0] cnt_nx, last_w;
   logic [IW-1:0] last_idx, rem_idx;
   logic          accept;
   logic          fin;
   logic [2:0]    fin_status;
   logic [15:0]   fin_grant;

   assign req_ext   = {{(SW-16){1'b0}}, req_size_ff};
   assign addr_ext  = {{(SW-16){1'b0}}, req_addr_ff};
   assign cnt_nx    = cnt_ff + CW'(1);
   assign last_w    = used_ff - CW'(1);
   assign last_idx  = last_w[IW-1:0];
   assign rem_idx   = used_ff[IW-1:0];
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   nfha_ram #(.WIDTH(SW), .DEPTH(MAX_SECTIONS)) u_ram_st (
      .clock(clock), .wr_en(we_st), .wr_addr(wa_st), .wr_data(wd_st),
      .rd_addr(rd_addr), .rd_data(rd_st));
   nfha_ram #(.WIDTH(SW), .DEPTH(MAX_SECTIONS)) u_ram_sz (
      .clock(clock), .wr_en(we_sz), .wr_addr(wa_sz), .wr_data(wd_sz),
      .rd_addr(rd_addr), .rd_data(rd_sz));
   nfha_ram #(.WIDTH(1), .DEPTH(MAX_SECTIONS)) u_ram_tk (
      .clock(clock), .wr_en(we_tk), .wr_addr(wa_tk), .wr_data(wd_tk),
      .rd_addr(rd_addr), .rd_data(rd_tk));
   nfha_ram #(.WIDTH(IW), .DEPTH(MAX_SECTIONS)) u_ram_nx (
      .clock(clock), .wr_en(we_nx), .wr_addr(wa_nx), .wr_data(wd_nx),
      .rd_addr(rd_addr), .rd_data(rd_nx));
   nfha_ram #(.WIDTH(IW), .DEPTH(MAX_SECTIONS)) u_ram_pv (
      .clock(clock), .wr_en(we_pv), .wr_addr(wa_pv), .wr_data(wd_pv),
      .rd_addr(rd_addr), .rd_data(rd_pv));

   nfha_alu #(.SW(SW), .HEADER_BYTES(HEADER_BYTES)) u_alu (
      .ctrl(alu_ctrl), .a(alu_a), .b(alu_b),
      .res(alu_res), .zero(alu_zero), .neg(alu_neg));

   always_comb begin
      case (state_ff)
         S_IDLE:   rd_addr = (req_data.op == OP_FREE) ? '0 : root_ff;
         S_A_SRCH: rd_addr = rd_nx;
         S_F_SCAN: rd_addr = cnt_nx[IW-1:0];
         S_M_RC:   rd_addr = cur_ff;
         S_M_LC:   rd_addr = phase_ff ? rd_nx : rd_pv;
         S_M_FH:   rd_addr = last_idx;
         default:  rd_addr = '0;
      endcase
   end

   always_comb begin
      alu_ctrl = '{sub_b: 1'b0, hdr: HDR_NONE};
      alu_a    = '0;
      alu_b    = '0;
      case (state_ff)
         S_A_SRCH: begin
            alu_a = rd_sz; alu_b = req_ext; alu_ctrl.sub_b = 1'b1;
         end
         S_A_FIT: begin
            alu_a = c_sz_ff; alu_b = req_ext;
            alu_ctrl = '{sub_b: 1'b1, hdr: HDR_SUB};
         end
         S_A_WHOLE: begin
            alu_a = free_ff; alu_b = c_sz_ff; alu_ctrl.sub_b = 1'b1;
         end
         S_A_SPL1: begin
            alu_a = c_st_ff; alu_b = req_ext; alu_ctrl.hdr = HDR_ADD;
         end
         S_A_SPL2: begin
            alu_a = free_ff; alu_b = req_ext;
            alu_ctrl = '{sub_b: 1'b1, hdr: HDR_SUB};
         end
         S_A_GRANT: begin
            alu_a = c_st_ff; alu_ctrl.hdr = HDR_ADD;
         end
         S_F_SCAN: begin
            alu_a = rd_st; alu_b = addr_ext;
            alu_ctrl = '{sub_b: 1'b1, hdr: HDR_ADD};
         end
         S_F_CHK: begin
            alu_a = free_ff; alu_b = c_sz_ff;
         end
         S_M_LO: begin
            alu_a = phase_ff ? c_st_ff : rd_st;
            alu_b = phase_ff ? c_sz_ff : rd_sz;
            alu_ctrl.hdr = HDR_ADD;
         end
         S_M_CMP: begin
            alu_a = tmp_ff; alu_b = phase_ff ? o_st_ff : c_st_ff;
            alu_ctrl.sub_b = 1'b1;
         end
         S_M_MRG: begin
            alu_a = l_sz_ff; alu_b = r_sz_ff; alu_ctrl.hdr = HDR_ADD;
         end
         S_M_FH: begin
            alu_a = free_ff; alu_ctrl.hdr = HDR_ADD;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      root_in      = root_ff;
      used_in      = used_ff;
      free_in      = free_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      phase_in     = phase_ff;
      req_size_in  = req_size_ff;
      req_addr_in  = req_addr_ff;
      c_st_in      = c_st_ff;
      c_sz_in      = c_sz_ff;
      c_tk_in      = c_tk_ff;
      c_nx_in      = c_nx_ff;
      o_idx_in     = o_idx_ff;
      o_st_in      = o_st_ff;
      o_sz_in      = o_sz_ff;
      o_tk_in      = o_tk_ff;
      o_nx_in      = o_nx_ff;
      tmp_in       = tmp_ff;
      l_idx_in     = l_idx_ff;
      l_sz_in      = l_sz_ff;
      r_idx_in     = r_idx_ff;
      r_sz_in      = r_sz_ff;
      r_nx_in      = r_nx_ff;
      lst_nx_in    = lst_nx_ff;
      lst_pv_in    = lst_pv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      fin          = 1'b0;
      fin_status   = ST_OK;
      fin_grant    = '0;
      we_st = 1'b0; wa_st = '0; wd_st = '0;
      we_sz = 1'b0; wa_sz = '0; wd_sz = '0;
      we_tk = 1'b0; wa_tk = '0; wd_tk = 1'b0;
      we_nx = 1'b0; wa_nx = '0; wd_nx = '0;
      we_pv = 1'b0; wa_pv = '0; wd_pv = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            we_st = 1'b1; we_sz = 1'b1; we_tk = 1'b1; we_nx = 1'b1; we_pv = 1'b1;
            wd_sz = HEAP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               req_size_in = req_data.req_size;
               req_addr_in = req_data.req_address;
               cnt_in      = '0;
               cur_in      = root_ff;
               if (req_data.op == OP_FREE) begin
                  state_in = S_F_SCAN;
               end else if (req_data.req_size == '0) begin
                  fin = 1'b1; fin_status = ST_ZERO_SIZE;
               end else begin
                  state_in = S_A_SRCH;
               end
            end
         end
         S_A_SRCH: begin
            if (!rd_tk && !alu_neg) begin
               c_st_in  = rd_st;
               c_sz_in  = rd_sz;
               c_nx_in  = rd_nx;
               state_in = S_A_FIT;
            end else if (cnt_nx == used_ff) begin
               fin = 1'b1; fin_status = ST_NO_SPACE;
            end else begin
               cnt_in = cnt_nx;
               cur_in = rd_nx;
            end
         end
         S_A_FIT: begin
            if (alu_neg || alu_zero) begin
               state_in = S_A_WHOLE;
            end else if (used_ff >= CW'(MAX_SECTIONS)) begin
               fin = 1'b1; fin_status = ST_FULL;
            end else begin
               tmp_in   = alu_res[SW-1:0];
               state_in = S_A_SPL1;
            end
         end
         S_A_WHOLE: begin
            free_in = alu_res[SW-1:0];
            we_tk = 1'b1; wa_tk = cur_ff; wd_tk = 1'b1;
            root_in  = c_nx_ff;
            state_in = S_A_GRANT;
         end
         S_A_SPL1: begin
            we_st = 1'b1; wa_st = rem_idx; wd_st = alu_res[SW-1:0];
            we_sz = 1'b1; wa_sz = rem_idx; wd_sz = tmp_ff;
            we_tk = 1'b1; wa_tk = rem_idx; wd_tk = 1'b0;
            we_nx = 1'b1; wa_nx = rem_idx; wd_nx = c_nx_ff;
            we_pv = 1'b1; wa_pv = rem_idx; wd_pv = cur_ff;
            state_in = S_A_SPL2;
         end
         S_A_SPL2: begin
            we_pv = 1'b1; wa_pv = c_nx_ff; wd_pv = rem_idx;
            we_nx = 1'b1; wa_nx = cur_ff;  wd_nx = rem_idx;
            we_sz = 1'b1; wa_sz = cur_ff;  wd_sz = req_ext;
            we_tk = 1'b1; wa_tk = cur_ff;  wd_tk = 1'b1;
            free_in  = alu_res[SW-1:0];
            used_in  = used_ff + CW'(1);
            root_in  = rem_idx;
            state_in = S_A_GRANT;
         end
         S_A_GRANT: begin
            fin = 1'b1; fin_status = ST_OK; fin_grant = alu_res[15:0];
         end
         S_F_SCAN: begin
            if (alu_zero) begin
               cur_in   = cnt_ff[IW-1:0];
               c_sz_in  = rd_sz;
               c_tk_in  = rd_tk;
               state_in = S_F_CHK;
            end else if (cnt_nx == used_ff) begin
               fin = 1'b1; fin_status = ST_UNKNOWN;
            end else begin
               cnt_in = cnt_nx;
            end
         end
         S_F_CHK: begin
            if (!c_tk_ff) begin
               fin = 1'b1; fin_status = ST_DOUBLE;
            end else begin
               we_tk = 1'b1; wa_tk = cur_ff; wd_tk = 1'b0;
               free_in  = alu_res[SW-1:0];
               phase_in = 1'b0;
               state_in = S_M_RC;
            end
         end
         S_M_RC: begin
            state_in = S_M_LC;
         end
         S_M_LC: begin
            c_st_in  = rd_st;
            c_sz_in  = rd_sz;
            c_nx_in  = rd_nx;
            o_idx_in = phase_ff ? rd_nx : rd_pv;
            state_in = S_M_LO;
         end
         S_M_LO: begin
            o_st_in  = rd_st;
            o_sz_in  = rd_sz;
            o_tk_in  = rd_tk;
            o_nx_in  = rd_nx;
            tmp_in   = alu_res[SW-1:0];
            state_in = S_M_CMP;
         end
         S_M_CMP: begin
            if ((o_idx_ff != cur_ff) && !o_tk_ff && alu_zero) begin
               if (phase_ff) begin
                  l_idx_in = cur_ff;   l_sz_in = c_sz_ff;
                  r_idx_in = o_idx_ff; r_sz_in = o_sz_ff; r_nx_in = o_nx_ff;
               end else begin
                  l_idx_in = o_idx_ff; l_sz_in = o_sz_ff;
                  r_idx_in = cur_ff;   r_sz_in = c_sz_ff; r_nx_in = c_nx_ff;
               end
               state_in = S_M_MRG;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               state_in = S_M_RC;
            end else begin
               fin = 1'b1; fin_status = ST_OK;
            end
         end
         S_M_MRG: begin
            we_sz = 1'b1; wa_sz = l_idx_ff; wd_sz = alu_res[SW-1:0];
            we_nx = 1'b1; wa_nx = l_idx_ff; wd_nx = r_nx_ff;
            we_pv = 1'b1; wa_pv = r_nx_ff;  wd_pv = l_idx_ff;
            if (root_ff == r_idx_ff) begin
               root_in = l_idx_ff;
            end
            state_in = S_M_FH;
         end
         S_M_FH: begin
            free_in = alu_res[SW-1:0];
            if (r_idx_ff == last_idx) begin
               used_in = last_w;
               cur_in  = l_idx_ff;
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  state_in = S_M_RC;
               end else begin
                  fin = 1'b1; fin_status = ST_OK;
               end
            end else begin
               state_in = S_RT_LD;
            end
         end
         S_RT_LD: begin
            we_st = 1'b1; wa_st = r_idx_ff; wd_st = rd_st;
            we_sz = 1'b1; wa_sz = r_idx_ff; wd_sz = rd_sz;
            we_tk = 1'b1; wa_tk = r_idx_ff; wd_tk = rd_tk;
            we_nx = 1'b1; wa_nx = r_idx_ff; wd_nx = rd_nx;
            we_pv = 1'b1; wa_pv = r_idx_ff; wd_pv = rd_pv;
            lst_nx_in = rd_nx;
            lst_pv_in = rd_pv;
            state_in  = S_RT_LNK;
         end
         S_RT_LNK: begin
            we_pv = 1'b1; wa_pv = lst_nx_ff; wd_pv = r_idx_ff;
            we_nx = 1'b1; wa_nx = lst_pv_ff; wd_nx = r_idx_ff;
            if (root_ff == last_idx) begin
               root_in = r_idx_ff;
            end
            cur_in  = (l_idx_ff == last_idx) ? r_idx_ff : l_idx_ff;
            used_in = last_w;
            if (!phase_ff) begin
               phase_in = 1'b1;
               state_in = S_M_RC;
            end else begin
               fin = 1'b1; fin_status = ST_OK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{grant_address: fin_grant, status: fin_status,
                          free_bytes: free_in[15:0]};
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         root_ff      <= '0;
         used_ff      <= CW'(1);
         free_ff      <= HEAP_INIT;
         cnt_ff       <= '0;
         cur_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
         cur_ff       <= cur_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff <= req_size_in;
      req_addr_ff <= req_addr_in;
      c_st_ff     <= c_st_in;
      c_sz_ff     <= c_sz_in;
      c_tk_ff     <= c_tk_in;
      c_nx_ff     <= c_nx_in;
      o_idx_ff    <= o_idx_in;
      o_st_ff     <= o_st_in;
      o_sz_ff     <= o_sz_in;
      o_tk_ff     <= o_tk_in;
      o_nx_ff     <= o_nx_in;
      tmp_ff      <= tmp_in;
      l_idx_ff    <= l_idx_in;
      l_sz_ff     <= l_sz_in;
      r_idx_ff    <= r_idx_in;
      r_sz_ff     <= r_sz_in;
      r_nx_ff     <= r_nx_in;
      lst_nx_ff   <= lst_nx_in;
      lst_pv_ff   <= lst_pv_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* src/nfha_ram.sv */
// ----------------------------------------------------------------------------
// nfha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/nfha_alu.sv */
// ----------------------------------------------------------------------------
// nfha_alu
// Shared adder: a plus or minus b, plus or minus one header, with flags.
// ----------------------------------------------------------------------------
module nfha_alu #(
   parameter int SW           = 17,
   parameter int HEADER_BYTES = 16
) (
   input  nfha_pkg::alu_ctrl_type ctrl,
   input  logic [SW-1:0]          a,
   input  logic [SW-1:0]          b,
   output logic [SW+1:0]          res,
   output logic                   zero,
   output logic                   neg
);
   import nfha_pkg::*;

   localparam int RW = SW + 2;

   logic [RW-1:0] ax;
   logic [RW-1:0] bx;
   logic [RW-1:0] hx;

   always_comb begin
      ax = {2'b00, a};
      bx = ctrl.sub_b ? (~{2'b00, b} + RW'(1)) : {2'b00, b};
      case (ctrl.hdr)
         HDR_ADD: hx = RW'(HEADER_BYTES);
         HDR_SUB: hx = ~RW'(HEADER_BYTES) + RW'(1);
         default: hx = '0;
      endcase
      res  = ax + bx + hx;
      neg  = res[RW-1];
      zero = (res == '0);
   end

endmodule

/* src/nfha_checker.sv */
// ----------------------------------------------------------------------------
// nfha_checker
// Port-level checks for the next-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module nfha_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input nfha_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input nfha_pkg::rsp_type rsp_data
);
   import nfha_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // hold a waiting request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting request changed");

   // one transfer at a time: either answered at once or busy
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid || !req_ready)
      else $error("second transfer taken while busy");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> rsp_data.grant_address == '0)
      else $error("grant address set on failed request");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_FULL)
      else $error("status code out of range");

endmodule

bind next_fit_heap_allocator_unit nfha_checker u_nfha_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
